FILE: src/drs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drs_pkg: shared constants for the discounted return RMS scaler
// Formats, widths of the working registers and configuration indexes.
// ----------------------------------------------------------------------------
package drs_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_WIDTH = 32;

    localparam int REW_W  = 32;
    localparam int DISC_W = 16;
    localparam int CLIP_W = 31;
    localparam int STAB_W = 16;
    localparam int CFG_W  = 31;
    localparam int IDX_W  = 2;

    localparam int K_FRAC = 16;
    localparam logic [DISC_W-1:0] K_DECAY = 16'd64881;
    localparam logic [DISC_W-1:0] K_GAIN  = 16'd655;

    localparam int NUM_W  = REW_W + FRAC_BITS;
    localparam int ACC_W  = 2 * DATA_WIDTH + K_FRAC + 2;
    localparam int RAD_W  = ACC_W - K_FRAC;
    localparam int ROOT_W = RAD_W / 2;
    localparam int CNT_W  = $clog2(NUM_W);

    localparam logic [IDX_W-1:0] CFG_DISCOUNT   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_CLIP_LIMIT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_STABILIZER = 2'd2;

    localparam logic [DISC_W-1:0]     DISCOUNT_RST = 16'd64881;
    localparam logic [CLIP_W-1:0]     CLIP_RST     = 31'd655360;
    localparam logic [STAB_W-1:0]     STAB_RST     = 16'd1;
    localparam logic [DATA_WIDTH-1:0] RMS_RST      = DATA_WIDTH'(1) << FRAC_BITS;

endpackage

`default_nettype wire

FILE: src/drs_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drs_if: request and result channels of the RMS scaler
// Valid/ready channels carrying one reward request or one scaled result.
// ----------------------------------------------------------------------------
interface drs_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] reward;
    logic        done_req;

    modport source (output valid, output mode, output reward, output done_req, input ready);
    modport sink   (input valid, input mode, input reward, input done_req, output ready);
endinterface

interface drs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] scaled_reward;
    logic [31:0] rms_value;

    modport source (output valid, output scaled_reward, output rms_value, input ready);
    modport sink   (input valid, input scaled_reward, input rms_value, output ready);
endinterface

`default_nettype wire

FILE: src/discounted_return_rms_scaler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// discounted_return_rms_scaler: running RMS reward scaling
// Scales each reward by the running RMS of the discounted return and, in
// update mode, advances the return and the RMS statistics.
// ----------------------------------------------------------------------------
// One request is in flight at a time; ready is low from acceptance until its
// result is taken. A scale-only request is latched, passes through the
// restoring divider (one quotient bit per cycle), is clamped and is then
// presented as the result. An update request adds, after the clamp, seven
// passes through the shared 32x32 multiplier with accumulation, a rounding
// step, the digit-by-digit square root and a write-back. The result register
// holds until the sink takes it.
// ----------------------------------------------------------------------------
module discounted_return_rms_scaler
    import drs_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_W-1:0]  i_cfg_data,
    drs_in_if.sink           i_req,
    drs_out_if.source        o_rsp
);

    localparam int W = DATA_WIDTH;

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_DIV     = 16'h0002,
        S_CLAMP   = 16'h0004,
        S_RET_MUL = 16'h0008,
        S_RET_ADD = 16'h0010,
        S_RMS_SQ  = 16'h0020,
        S_DEC_LO  = 16'h0040,
        S_DEC_HI  = 16'h0080,
        S_RET_SQ  = 16'h0100,
        S_GAIN_LO = 16'h0200,
        S_GAIN_HI = 16'h0400,
        S_ACC     = 16'h0800,
        S_ROUND   = 16'h1000,
        S_SQRT    = 16'h2000,
        S_FIN     = 16'h4000,
        S_OUT     = 16'h8000
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_mode, n_mode;
    logic              r_done, n_done;
    logic [REW_W-1:0]  r_reward, n_reward;
    logic [W:0]        r_den, n_den;
    logic [NUM_W-1:0]  r_num, n_num;
    logic [W:0]        r_drem, n_drem;
    logic [REW_W-1:0]  r_scaled, n_scaled;
    logic [2*W-1:0]    r_prod, n_prod;
    logic [2*W-1:0]    r_sq, n_sq;
    logic              r_shift, n_shift;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [W-1:0]      r_ret, n_ret;
    logic [W-1:0]      r_am, n_am;
    logic [RAD_W-1:0]  r_rad, n_rad;
    logic [W+1:0]      r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [W-1:0]      r_dret, n_dret;
    logic [W-1:0]      r_rms, n_rms;
    logic [DISC_W-1:0] r_discount, n_discount;
    logic [CLIP_W-1:0] r_clip, n_clip;
    logic [STAB_W-1:0] r_stab, n_stab;

    logic [W-1:0]      mul_a;
    logic [W-1:0]      mul_b;
    logic [2*W-1:0]    mul_p;
    logic [ACC_W-1:0]  acc_add;
    logic [REW_W-1:0]  req_mag;
    logic [W+1:0]      div_sh;
    logic              div_ge;
    logic [CLIP_W-1:0] q_clamp;
    logic [W+16:0]     dm_sum;
    logic [W:0]        dm;
    logic [W+2:0]      sdm;
    logic [W+2:0]      ret_w;
    logic [W-1:0]      ret_sat;
    logic [W+3:0]      sq_sh;
    logic [W+3:0]      sq_trial;
    logic              sq_ge;

    assign mul_p   = mul_a * mul_b;
    assign acc_add = r_acc + (r_shift ? ACC_W'({r_prod, {W{1'b0}}}) : ACC_W'(r_prod));

    assign req_mag = i_req.reward[REW_W-1] ? (REW_W'(0) - i_req.reward) : i_req.reward;

    assign div_sh = {r_drem, r_num[NUM_W-1]};
    assign div_ge = (div_sh >= {1'b0, r_den});

    assign dm_sum  = (W+17)'(r_prod[W+15:0]) + (W+17)'(1 << (K_FRAC - 1));
    assign dm      = dm_sum[W+16:16];
    assign sdm     = r_dret[W-1] ? ((W+3)'(0) - (W+3)'(dm)) : (W+3)'(dm);
    assign ret_w   = sdm + {{(W+3-REW_W){r_reward[REW_W-1]}}, r_reward};

    assign sq_sh    = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);

    always_comb begin
        if (r_den == '0) begin
            q_clamp = (r_reward == '0) ? '0 : r_clip;
        end else if (r_num > NUM_W'(r_clip)) begin
            q_clamp = r_clip;
        end else begin
            q_clamp = r_num[CLIP_W-1:0];
        end
    end

    always_comb begin
        if (ret_w[W+2:W-1] == '0 || ret_w[W+2:W-1] == '1) begin
            ret_sat = ret_w[W-1:0];
        end else if (ret_w[W+2]) begin
            ret_sat = {1'b1, {(W-1){1'b0}}};
        end else begin
            ret_sat = {1'b0, {(W-1){1'b1}}};
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_mode     = r_mode;
        n_done     = r_done;
        n_reward   = r_reward;
        n_den      = r_den;
        n_num      = r_num;
        n_drem     = r_drem;
        n_scaled   = r_scaled;
        n_prod     = r_prod;
        n_sq       = r_sq;
        n_shift    = r_shift;
        n_acc      = r_acc;
        n_ret      = r_ret;
        n_am       = r_am;
        n_rad      = r_rad;
        n_rem      = r_rem;
        n_root     = r_root;
        n_dret     = r_dret;
        n_rms      = r_rms;
        n_discount = r_discount;
        n_clip     = r_clip;
        n_stab     = r_stab;
        mul_a      = '0;
        mul_b      = '0;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DISCOUNT:   n_discount = i_cfg_data[DISC_W-1:0];
                CFG_CLIP_LIMIT: n_clip     = i_cfg_data[CLIP_W-1:0];
                CFG_STABILIZER: n_stab     = i_cfg_data[STAB_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_mode   = i_req.mode;
                    n_done   = i_req.done_req;
                    n_reward = i_req.reward;
                    n_num    = {req_mag, {FRAC_BITS{1'b0}}};
                    n_den    = (W+1)'(r_rms) + (W+1)'(r_stab);
                    n_drem   = '0;
                    n_cnt    = CNT_W'(NUM_W - 1);
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                n_drem = div_ge ? (W+1)'(div_sh - {1'b0, r_den}) : div_sh[W:0];
                n_num  = {r_num[NUM_W-2:0], div_ge};
                if (r_cnt == '0) begin
                    n_state = S_CLAMP;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_CLAMP: begin
                n_scaled = r_reward[REW_W-1] ? (REW_W'(0) - {1'b0, q_clamp}) : {1'b0, q_clamp};
                n_state  = r_mode ? S_RET_MUL : S_OUT;
            end
            S_RET_MUL: begin
                mul_a   = r_dret[W-1] ? (W'(0) - r_dret) : r_dret;
                mul_b   = W'(r_discount);
                n_prod  = mul_p;
                n_state = S_RET_ADD;
            end
            S_RET_ADD: begin
                n_ret   = ret_sat;
                n_am    = ret_sat[W-1] ? (W'(0) - ret_sat) : ret_sat;
                n_state = S_RMS_SQ;
            end
            S_RMS_SQ: begin
                mul_a   = r_rms;
                mul_b   = r_rms;
                n_sq    = mul_p;
                n_acc   = '0;
                n_state = S_DEC_LO;
            end
            S_DEC_LO: begin
                mul_a   = r_sq[W-1:0];
                mul_b   = W'(K_DECAY);
                n_prod  = mul_p;
                n_shift = 1'b0;
                n_state = S_DEC_HI;
            end
            S_DEC_HI: begin
                n_acc   = acc_add;
                mul_a   = r_sq[2*W-1:W];
                mul_b   = W'(K_DECAY);
                n_prod  = mul_p;
                n_shift = 1'b1;
                n_state = S_RET_SQ;
            end
            S_RET_SQ: begin
                n_acc   = acc_add;
                mul_a   = r_am;
                mul_b   = r_am;
                n_sq    = mul_p;
                n_state = S_GAIN_LO;
            end
            S_GAIN_LO: begin
                mul_a   = r_sq[W-1:0];
                mul_b   = W'(K_GAIN);
                n_prod  = mul_p;
                n_shift = 1'b0;
                n_state = S_GAIN_HI;
            end
            S_GAIN_HI: begin
                n_acc   = acc_add;
                mul_a   = r_sq[2*W-1:W];
                mul_b   = W'(K_GAIN);
                n_prod  = mul_p;
                n_shift = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                n_acc   = acc_add;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                n_rad   = RAD_W'((r_acc + ACC_W'(1 << (K_FRAC - 1))) >> K_FRAC);
                n_rem   = '0;
                n_root  = '0;
                n_cnt   = CNT_W'(ROOT_W - 1);
                n_state = S_SQRT;
            end
            S_SQRT: begin
                n_rem  = sq_ge ? (W+2)'(sq_sh - sq_trial) : sq_sh[W+1:0];
                n_root = {r_root[ROOT_W-2:0], sq_ge};
                n_rad  = {r_rad[RAD_W-3:0], 2'b00};
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_FIN: begin
                n_rms   = (r_root[ROOT_W-1:W] != '0) ? '1 : r_root[W-1:0];
                n_dret  = r_done ? '0 : r_ret;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_dret     <= '0;
            r_rms      <= RMS_RST;
            r_discount <= DISCOUNT_RST;
            r_clip     <= CLIP_RST;
            r_stab     <= STAB_RST;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_dret     <= n_dret;
            r_rms      <= n_rms;
            r_discount <= n_discount;
            r_clip     <= n_clip;
            r_stab     <= n_stab;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_done   <= n_done;
        r_reward <= n_reward;
        r_den    <= n_den;
        r_num    <= n_num;
        r_drem   <= n_drem;
        r_scaled <= n_scaled;
        r_prod   <= n_prod;
        r_sq     <= n_sq;
        r_shift  <= n_shift;
        r_acc    <= n_acc;
        r_ret    <= n_ret;
        r_am     <= n_am;
        r_rad    <= n_rad;
        r_rem    <= n_rem;
        r_root   <= n_root;
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = (r_state == S_OUT);
    assign o_rsp.scaled_reward = r_scaled;
    assign o_rsp.rms_value     = r_rms;

endmodule

`default_nettype wire

FILE: test/drs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drs_checker: result checker for the discounted return RMS scaler
// Watches the configuration port and both channels. It keeps its own copy of
// the registers, the discounted return and the running RMS. For each accepted
// request it computes the scaled reward and RMS, and compares each accepted
// result field by field against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module drs_checker
    import drs_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_W-1:0]  i_cfg_data,
    input  wire              i_req_valid,
    input  wire              i_req_ready,
    input  wire              i_req_mode,
    input  wire [REW_W-1:0]  i_req_reward,
    input  wire              i_req_done,
    input  wire              i_rsp_valid,
    input  wire              i_rsp_ready,
    input  wire [31:0]       i_rsp_scaled,
    input  wire [31:0]       i_rsp_rms,
    output int               o_err_cnt,
    output int               o_pending
);

    typedef struct packed {
        logic [31:0] scaled;
        logic [31:0] rms;
    } t_scaled_rms;

    localparam logic signed [63:0] RET_MAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] RET_MIN = -RET_MAX - 64'sd1;
    localparam logic [63:0]        RMS_MAX = (64'd1 << DATA_WIDTH) - 64'd1;

    logic [DISC_W-1:0]            discount_q;
    logic [CLIP_W-1:0]            clip_q;
    logic [STAB_W-1:0]            stab_q;
    logic signed [DATA_WIDTH-1:0] return_q;
    logic [DATA_WIDTH-1:0]        rms_q;
    t_scaled_rms                  scaled_rms_due[$];
    int                           errs = 0;

    function automatic logic [63:0] floor_root(input logic [127:0] x);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 40; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= x) r = c;
        end
        return r;
    endfunction

    task automatic rms_scale_step(input logic mode, input logic [31:0] reward_bits,
                                  input logic done, output t_scaled_rms res);
        logic signed [63:0] reward;
        logic signed [63:0] ret_w;
        logic signed [63:0] ret;
        logic signed [63:0] dm;
        logic [63:0]        rmag;
        logic [63:0]        den;
        logic [63:0]        quo;
        logic [63:0]        am;
        logic [63:0]        pm;
        logic [127:0]       acc;
        logic [63:0]        root;
        reward = {{32{reward_bits[31]}}, reward_bits};
        rmag   = reward_bits[31] ? 64'(-reward) : 64'(reward);
        den    = 64'(rms_q) + 64'(stab_q);
        if (den == 64'd0) begin
            quo = (rmag == 64'd0) ? 64'd0 : 64'(clip_q);
        end else begin
            quo = (rmag << FRAC_BITS) / den;
            if (quo > 64'(clip_q)) quo = 64'(clip_q);
        end
        res.scaled = reward_bits[31] ? 32'(-quo) : 32'(quo);

        if (mode) begin
            ret_w = return_q;
            am    = (ret_w < 0) ? 64'(-ret_w) : 64'(ret_w);
            pm    = am * 64'(discount_q);
            dm    = (pm + 64'd32768) >> 16;
            ret   = ((ret_w < 0) ? -dm : dm) + reward;
            if (ret > RET_MAX) ret = RET_MAX;
            if (ret < RET_MIN) ret = RET_MIN;
            am    = (ret < 0) ? 64'(-ret) : 64'(ret);
            acc   = 128'(rms_q) * 128'(K_DECAY) * 128'(rms_q)
                  + 128'(am) * 128'(K_GAIN) * 128'(am) + 128'd32768;
            acc   = acc >> K_FRAC;
            root  = floor_root(acc);
            rms_q = (root > RMS_MAX) ? RMS_MAX[DATA_WIDTH-1:0] : root[DATA_WIDTH-1:0];
            return_q = done ? '0 : ret[DATA_WIDTH-1:0];
        end
        res.rms = (64'(rms_q) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(rms_q);
    endtask

    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        errs++;
        if (errs <= 10)
            $display("[%0t] %s differs: expected %h, got %h", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin : watch
        t_scaled_rms want;
        if (!i_rst_n) begin
            discount_q = DISCOUNT_RST;
            clip_q     = CLIP_RST;
            stab_q     = STAB_RST;
            return_q   = '0;
            rms_q      = RMS_RST;
            scaled_rms_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DISCOUNT:   discount_q = i_cfg_data[DISC_W-1:0];
                    CFG_CLIP_LIMIT: clip_q     = i_cfg_data[CLIP_W-1:0];
                    CFG_STABILIZER: stab_q     = i_cfg_data[STAB_W-1:0];
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) begin
                rms_scale_step(i_req_mode, i_req_reward, i_req_done, want);
                scaled_rms_due.push_back(want);
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (scaled_rms_due.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("[%0t] result with nothing outstanding: scaled %h rms %h",
                                 $time, i_rsp_scaled, i_rsp_rms);
                end else begin
                    want = scaled_rms_due.pop_front();
                    if (i_rsp_scaled !== want.scaled)
                        flag_field("scaled_reward", want.scaled, i_rsp_scaled);
                    if (i_rsp_rms !== want.rms)
                        flag_field("rms_value", want.rms, i_rsp_rms);
                end
            end
        end
        o_pending <= scaled_rms_due.size();
        o_err_cnt <= errs;
    end

endmodule

`default_nettype wire

FILE: test/discounted_return_rms_scaler_tb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// discounted_return_rms_scaler_tb: top level test of the RMS reward scaler
// Drives directed extremes and then phases of random requests under several
// register settings, with bursty requests and a stalling result sink. The
// checker beside the block does the prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module discounted_return_rms_scaler_tb;
    import drs_pkg::*;

    localparam int ITEMS       = 950;
    localparam int PHASES      = 8;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TAIL_CYCLES = 120;

    localparam logic [IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef enum logic [1:0] {SINK_EAGER, SINK_COIN, SINK_SLUGGISH} t_sink_style;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               cfg_we     = 1'b0;
    logic [IDX_W-1:0]   cfg_idx    = '0;
    logic [CFG_W-1:0]   cfg_data   = '0;
    logic               req_valid  = 1'b0;
    logic               req_mode   = 1'b0;
    logic [31:0]        req_reward = '0;
    logic               req_done   = 1'b0;
    logic               rsp_ready  = 1'b0;
    int                 err_cnt;
    int                 pending;
    int                 cycles     = 0;
    int                 burst_left = 0;
    t_sink_style        sink_style = SINK_EAGER;
    int                 style_left = 0;

    drs_in_if  req_if ();
    drs_out_if rsp_if ();

    assign req_if.valid    = req_valid;
    assign req_if.mode     = req_mode;
    assign req_if.reward   = req_reward;
    assign req_if.done_req = req_done;
    assign rsp_if.ready    = rsp_ready;

    discounted_return_rms_scaler uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    drs_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_req_valid  (req_if.valid),
        .i_req_ready  (req_if.ready),
        .i_req_mode   (req_if.mode),
        .i_req_reward (req_if.reward),
        .i_req_done   (req_if.done_req),
        .i_rsp_valid  (rsp_if.valid),
        .i_rsp_ready  (rsp_if.ready),
        .i_rsp_scaled (rsp_if.scaled_reward),
        .i_rsp_rms    (rsp_if.rms_value),
        .o_err_cnt    (err_cnt),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (style_left == 0) begin
            sink_style <= t_sink_style'($urandom_range(0, 2));
            style_left <= $urandom_range(64, 600);
        end else begin
            style_left <= style_left - 1;
        end
        case (sink_style)
            SINK_EAGER:    rsp_ready <= 1'b1;
            SINK_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
            default:       rsp_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    task automatic push_request(input logic m, input logic [31:0] r, input logic d);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 110)
                                              : $urandom_range(0, 12);
            if (gap > 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        req_valid  <= 1'b1;
        req_mode   <= m;
        req_reward <= r;
        req_done   <= d;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_regs(input logic [15:0] disc, input logic [30:0] clip,
                              input logic [15:0] stab);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_DISCOUNT;
        cfg_data <= {15'($urandom), disc};
        @(posedge i_clk);
        cfg_idx  <= CFG_CLIP_LIMIT;
        cfg_data <= clip;
        @(posedge i_clk);
        cfg_idx  <= CFG_STABILIZER;
        cfg_data <= {15'($urandom), stab};
        @(posedge i_clk);
        cfg_idx  <= CFG_UNMAPPED;
        cfg_data <= 31'($urandom);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin : stimulus
        logic        m;
        logic        d;
        logic [31:0] r;
        int          pick;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values
        push_request(1'b0, 32'h0000_0000, 1'b0);
        push_request(1'b0, 32'h7FFF_FFFF, 1'b0);
        push_request(1'b0, 32'h8000_0000, 1'b0);
        push_request(1'b0, 32'h0000_0001, 1'b0);
        push_request(1'b0, 32'hFFFF_FFFF, 1'b0);
        push_request(1'b0, 32'h0001_0000, 1'b1);
        push_request(1'b1, 32'h0001_0000, 1'b0);
        push_request(1'b1, 32'h0002_0000, 1'b1);
        push_request(1'b1, 32'h7FFF_FFFF, 1'b0);
        push_request(1'b1, 32'h7FFF_FFFF, 1'b0);
        push_request(1'b1, 32'h8000_0000, 1'b0);
        push_request(1'b1, 32'h8000_0000, 1'b0);
        push_request(1'b1, 32'h8000_0000, 1'b1);
        push_request(1'b0, 32'hFFFE_0000, 1'b0);

        // widest settings, no stabilizer
        wait_idle();
        write_regs(16'hFFFF, 31'h7FFF_FFFF, 16'h0000);
        push_request(1'b0, 32'h7FFF_FFFF, 1'b0);
        push_request(1'b0, 32'h8000_0000, 1'b0);
        push_request(1'b1, 32'h7FFF_FFFF, 1'b0);
        push_request(1'b1, 32'h7FFF_FFFF, 1'b1);
        push_request(1'b1, 32'h0000_0000, 1'b0);
        push_request(1'b0, 32'h0000_0000, 1'b1);
        push_request(1'b1, 32'hFFFF_FFFF, 1'b0);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (ph)
                0:       write_regs(16'd64881, 31'd655360, 16'd1);
                1:       write_regs(16'd0, 31'd0, 16'd0);
                2:       write_regs(16'hFFFF, 31'h7FFF_FFFF, 16'hFFFF);
                3:       write_regs(16'd32768, 31'd65536, 16'd0);
                default: write_regs(16'($urandom), 31'($urandom_range(0, 32'h00FF_FFFF)),
                                    16'($urandom));
            endcase
            for (int n = 0; n < ITEMS / PHASES; n++) begin
                m    = ($urandom_range(0, 9) < 7);
                d    = ($urandom_range(0, 11) == 0);
                pick = $urandom_range(0, 99);
                if (pick < (m ? 3 : 40)) begin
                    r = $urandom;
                end else if (pick < (m ? 8 : 50)) begin
                    case ($urandom_range(0, 4))
                        0:       r = 32'h7FFF_FFFF;
                        1:       r = 32'h8000_0000;
                        2:       r = 32'h0000_0000;
                        3:       r = 32'h0000_0001;
                        default: r = 32'hFFFF_FFFF;
                    endcase
                end else begin
                    r = $urandom_range(0, 32'h0008_0000);
                    if ($urandom_range(0, 1)) r = -r;
                end
                push_request(m, r, d);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
src/drs_pkg.sv
src/drs_if.sv
src/discounted_return_rms_scaler.sv
test/drs_checker.sv
test/discounted_return_rms_scaler_tb.sv
